FILE: design/utf8_pkg.sv
// Shared types, codes and lookup functions of the UTF-8 decoder.
package utf8_pkg;

    // Byte classes of the decoding automaton
    typedef enum logic [3:0] {
        CLS_ASCII    = 4'd0,   // 00..7F
        CLS_CONT_LO  = 4'd1,   // 80..8F
        CLS_LEAD2    = 4'd2,   // C2..DF
        CLS_LEAD3    = 4'd3,   // E1..EC, EE..EF
        CLS_LEAD_ED  = 4'd4,   // ED
        CLS_LEAD_F4  = 4'd5,   // F4
        CLS_LEAD4    = 4'd6,   // F1..F3
        CLS_CONT_HI  = 4'd7,   // A0..BF
        CLS_INVALID  = 4'd8,   // C0, C1, F5..FF
        CLS_CONT_MID = 4'd9,   // 90..9F
        CLS_LEAD_E0  = 4'd10,  // E0
        CLS_LEAD_F0  = 4'd11   // F0
    } t_byte_class;

    typedef enum logic [8:0] {
        ST_ACCEPT = 9'b000000001,
        ST_REJECT = 9'b000000010,
        ST_TAIL1  = 9'b000000100,  // one continuation byte left
        ST_TAIL2  = 9'b000001000,  // two continuation bytes left
        ST_E0_2ND = 9'b000010000,  // after E0: needs A0..BF
        ST_ED_2ND = 9'b000100000,  // after ED: needs 80..9F
        ST_F0_2ND = 9'b001000000,  // after F0: needs 90..BF
        ST_TAIL3  = 9'b010000000,  // three continuation bytes left
        ST_F4_2ND = 9'b100000000   // after F4: needs 80..8F
    } t_dfa_state;

    localparam int unsigned CODE_W  = 21;
    localparam int unsigned COUNT_W = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]  code_value;
        logic               char_done;
        logic               bad_sequence;
        logic [COUNT_W-1:0] char_count;
        logic [COUNT_W-1:0] bytes_to_accept;
    } t_out_item;

    // Registered request between the front stage and the decode core
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        t_byte_class byte_cls;
    } t_stage;

    function automatic t_byte_class byte_class(input logic [7:0] b);
        t_byte_class c;
        if (b < 8'h80)       c = CLS_ASCII;
        else if (b < 8'h90)  c = CLS_CONT_LO;
        else if (b < 8'hA0)  c = CLS_CONT_MID;
        else if (b < 8'hC0)  c = CLS_CONT_HI;
        else if (b < 8'hC2)  c = CLS_INVALID;
        else if (b < 8'hE0)  c = CLS_LEAD2;
        else if (b == 8'hE0) c = CLS_LEAD_E0;
        else if (b == 8'hED) c = CLS_LEAD_ED;
        else if (b < 8'hF0)  c = CLS_LEAD3;
        else if (b == 8'hF0) c = CLS_LEAD_F0;
        else if (b < 8'hF4)  c = CLS_LEAD4;
        else if (b == 8'hF4) c = CLS_LEAD_F4;
        else                 c = CLS_INVALID;
        return c;
    endfunction

    function automatic t_dfa_state dfa_next(input t_dfa_state s, input t_byte_class c);
        t_dfa_state n;
        n = ST_REJECT;
        unique case (s)
            ST_ACCEPT: begin
                case (c)
                    CLS_ASCII:   n = ST_ACCEPT;
                    CLS_LEAD2:   n = ST_TAIL1;
                    CLS_LEAD3:   n = ST_TAIL2;
                    CLS_LEAD_ED: n = ST_ED_2ND;
                    CLS_LEAD_F4: n = ST_F4_2ND;
                    CLS_LEAD4:   n = ST_TAIL3;
                    CLS_LEAD_E0: n = ST_E0_2ND;
                    CLS_LEAD_F0: n = ST_F0_2ND;
                    default:     n = ST_REJECT;
                endcase
            end
            ST_REJECT: n = ST_REJECT;
            ST_TAIL1: begin
                case (c) inside
                    CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI: n = ST_ACCEPT;
                    default:                                n = ST_REJECT;
                endcase
            end
            ST_TAIL2: begin
                case (c) inside
                    CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI: n = ST_TAIL1;
                    default:                                n = ST_REJECT;
                endcase
            end
            ST_E0_2ND: n = (c == CLS_CONT_HI) ? ST_TAIL1 : ST_REJECT;
            ST_ED_2ND: begin
                case (c) inside
                    CLS_CONT_LO, CLS_CONT_MID: n = ST_TAIL1;
                    default:                   n = ST_REJECT;
                endcase
            end
            ST_F0_2ND: begin
                case (c) inside
                    CLS_CONT_MID, CLS_CONT_HI: n = ST_TAIL2;
                    default:                   n = ST_REJECT;
                endcase
            end
            ST_TAIL3: begin
                case (c) inside
                    CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI: n = ST_TAIL2;
                    default:                                n = ST_REJECT;
                endcase
            end
            ST_F4_2ND: n = (c == CLS_CONT_LO) ? ST_TAIL2 : ST_REJECT;
            default:   n = ST_REJECT;
        endcase
        return n;
    endfunction

endpackage

FILE: design/utf8_if.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface utf8_in_if import utf8_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface utf8_out_if import utf8_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/utf8_dfa_decoder.sv
// Validating UTF-8 decoder, one byte request in and one result out per cycle
// while the output is not stalled: each byte passes an input register, where its
// character class is formed, and then a single automaton step into the result
// register, so the input register and the result register lie between a byte
// and its result. The automaton state, accumulator and counters in the decode
// core update on each byte it takes. A byte flagged last closes the string.
module utf8_dfa_decoder import utf8_pkg::*; #(
    parameter int unsigned MAX_STRING_BYTES = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utf8_in_if.sink           i_in,
    utf8_out_if.source        o_out
);

    logic   stage_valid;
    logic   stage_ready;
    t_stage stage;

    utf8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.data),
        .o_valid (stage_valid),
        .i_ready (stage_ready),
        .o_stage (stage)
    );

    utf8_core #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .o_ready (stage_ready),
        .i_stage (stage),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.data)
    );

endmodule

FILE: design/utf8_front.sv
// Input register stage: captures a byte request and its character class.
module utf8_front import utf8_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_stage   o_stage
);

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_stage.data_byte = i_item.data_byte;
        n_stage.last_byte = i_item.last_byte;
        n_stage.byte_cls  = byte_class(i_item.data_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: design/utf8_core.sv
// Decode core: automaton step, codepoint accumulator, counters and result register.
module utf8_core import utf8_pkg::*; #(
    parameter int unsigned MAX_STRING_BYTES = 65535
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_stage    i_stage,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam logic [COUNT_W-1:0] COUNT_CAP = (MAX_STRING_BYTES < 65535) ?
        COUNT_W'(MAX_STRING_BYTES) : {COUNT_W{1'b1}};

    t_dfa_state         r_state, n_state;
    logic [CODE_W-1:0]  r_acc, n_acc;
    logic [COUNT_W-1:0] r_point_cnt, n_point_cnt;
    logic [COUNT_W-1:0] r_byte_pos, n_byte_pos;
    logic [COUNT_W-1:0] r_accept_pos, n_accept_pos;
    logic               r_out_valid;
    t_out_item          r_out, n_out;
    logic               take;
    logic [7:0]         lead_bits;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v < COUNT_CAP) ? v + 1'b1 : COUNT_CAP;
    endfunction

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        // mask a byte taken in the accept state by its class; in any other state a byte adds six payload bits
        lead_bits = i_stage.data_byte & (8'hFF >> i_stage.byte_cls);
        if (r_state != ST_ACCEPT) begin
            n_acc = {r_acc[CODE_W-7:0], i_stage.data_byte[5:0]};
        end else begin
            n_acc = {{(CODE_W-8){1'b0}}, lead_bits};
        end

        n_state      = dfa_next(r_state, i_stage.byte_cls);
        n_point_cnt  = r_point_cnt;
        n_accept_pos = r_accept_pos;
        if (n_state == ST_ACCEPT) begin
            n_point_cnt  = sat_inc(r_point_cnt);
            n_accept_pos = sat_inc(r_byte_pos);
        end
        n_byte_pos = sat_inc(r_byte_pos);

        n_out.code_value      = n_acc;
        n_out.char_done       = (n_state == ST_ACCEPT);
        n_out.bad_sequence    = (n_state == ST_REJECT);
        n_out.char_count      = n_point_cnt;
        n_out.bytes_to_accept = (n_accept_pos == '0) ? COUNT_W'(1) : n_accept_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_ACCEPT;
            r_acc        <= '0;
            r_point_cnt  <= '0;
            r_byte_pos   <= '0;
            r_accept_pos <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (take) begin
                if (i_stage.last_byte) begin
                    // end of string: return to the start state
                    r_state      <= ST_ACCEPT;
                    r_acc        <= '0;
                    r_point_cnt  <= '0;
                    r_byte_pos   <= '0;
                    r_accept_pos <= '0;
                end else begin
                    r_state      <= n_state;
                    r_acc        <= n_acc;
                    r_point_cnt  <= n_point_cnt;
                    r_byte_pos   <= n_byte_pos;
                    r_accept_pos <= n_accept_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("decoder state not one-hot");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_stage.last_byte |=> r_state == ST_ACCEPT && r_point_cnt == '0 &&
            r_byte_pos == '0 && r_accept_pos == '0)
        else $error("string state not cleared after last byte");

    a_reject_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_stage.last_byte && r_state == ST_REJECT |=> r_state == ST_REJECT)
        else $error("reject state left before end of string");

    a_counts_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point_cnt <= COUNT_CAP && r_byte_pos <= COUNT_CAP)
        else $error("count above limit");

    a_accept_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accept_pos <= r_byte_pos && r_point_cnt <= r_byte_pos)
        else $error("accept position or char count past byte position");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the streaming UTF-8 decoder: directed, random and long strings.
module tb;
    import utf8_pkg::*;

    localparam int unsigned MAX_BYTES      = 65535;
    localparam int unsigned COUNT_CAP      = (MAX_BYTES < 65535) ? MAX_BYTES : 65535;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 10;

    class utf8_decode_scoreboard;
        t_dfa_state          dfa;
        logic [CODE_W-1:0]   code_acc;
        logic [COUNT_W-1:0]  points;
        logic [COUNT_W-1:0]  byte_pos;
        logic [COUNT_W-1:0]  accept_pos;
        t_out_item           expected_q[$];
        int unsigned         mismatches;
        int unsigned         results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            clear_string();
        endfunction

        function void clear_string();
            dfa        = ST_ACCEPT;
            code_acc   = '0;
            points     = '0;
            byte_pos   = '0;
            accept_pos = '0;
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
            return (v < COUNT_CAP) ? v + 1'b1 : COUNT_CAP[COUNT_W-1:0];
        endfunction

        // Step the decoder by one accepted byte and queue the result it owes.
        function void note_byte(t_in_item it);
            t_byte_class cls;
            t_dfa_state  nxt;
            t_out_item   want;
            logic        any_cont;
            logic [7:0]  b;
            b = it.data_byte;
            if (b < 8'h80)                    cls = CLS_ASCII;
            else if (b < 8'h90)               cls = CLS_CONT_LO;
            else if (b < 8'hA0)               cls = CLS_CONT_MID;
            else if (b < 8'hC0)               cls = CLS_CONT_HI;
            else if (b == 8'hE0)              cls = CLS_LEAD_E0;
            else if (b == 8'hED)              cls = CLS_LEAD_ED;
            else if (b == 8'hF0)              cls = CLS_LEAD_F0;
            else if (b == 8'hF4)              cls = CLS_LEAD_F4;
            else if (b < 8'hC2 || b > 8'hF4)  cls = CLS_INVALID;
            else if (b < 8'hE0)               cls = CLS_LEAD2;
            else if (b < 8'hF0)               cls = CLS_LEAD3;
            else                              cls = CLS_LEAD4;
            any_cont = (cls == CLS_CONT_LO) || (cls == CLS_CONT_MID) || (cls == CLS_CONT_HI);

            // a byte in the accept state loads its masked payload, in any other state it shifts six bits in
            if (dfa == ST_ACCEPT)
                code_acc = {{(CODE_W-8){1'b0}}, b & (8'hFF >> cls)};
            else
                code_acc = {code_acc[CODE_W-7:0], b[5:0]};

            nxt = ST_REJECT;
            case (dfa)
                ST_ACCEPT: begin
                    case (cls)
                        CLS_ASCII:   nxt = ST_ACCEPT;
                        CLS_LEAD2:   nxt = ST_TAIL1;
                        CLS_LEAD3:   nxt = ST_TAIL2;
                        CLS_LEAD4:   nxt = ST_TAIL3;
                        CLS_LEAD_E0: nxt = ST_E0_2ND;
                        CLS_LEAD_ED: nxt = ST_ED_2ND;
                        CLS_LEAD_F0: nxt = ST_F0_2ND;
                        CLS_LEAD_F4: nxt = ST_F4_2ND;
                        default:     nxt = ST_REJECT;
                    endcase
                end
                ST_TAIL1:  if (any_cont) nxt = ST_ACCEPT;
                ST_TAIL2:  if (any_cont) nxt = ST_TAIL1;
                ST_TAIL3:  if (any_cont) nxt = ST_TAIL2;
                ST_E0_2ND: if (cls == CLS_CONT_HI) nxt = ST_TAIL1;
                ST_ED_2ND: if (cls == CLS_CONT_LO || cls == CLS_CONT_MID) nxt = ST_TAIL1;
                ST_F0_2ND: if (cls == CLS_CONT_MID || cls == CLS_CONT_HI) nxt = ST_TAIL2;
                ST_F4_2ND: if (cls == CLS_CONT_LO) nxt = ST_TAIL2;
                default:   nxt = ST_REJECT;
            endcase
            dfa = nxt;

            if (dfa == ST_ACCEPT) begin
                points     = bump(points);
                accept_pos = bump(byte_pos);
            end
            byte_pos = bump(byte_pos);

            want.code_value      = code_acc;
            want.char_done       = (dfa == ST_ACCEPT);
            want.bad_sequence    = (dfa == ST_REJECT);
            want.char_count      = points;
            want.bytes_to_accept = (accept_pos == '0) ? COUNT_W'(1) : accept_pos;
            expected_q.push_back(want);

            if (it.last_byte)
                clear_string();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: result %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, results_seen, what, got, want);
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report("unexpected result, code_value", 32'(got.code_value), '0);
            end else begin
                want = expected_q.pop_front();
                if (got.code_value !== want.code_value)
                    report("code_value", 32'(got.code_value), 32'(want.code_value));
                if (got.char_done !== want.char_done)
                    report("char_done", 32'(got.char_done), 32'(want.char_done));
                if (got.bad_sequence !== want.bad_sequence)
                    report("bad_sequence", 32'(got.bad_sequence), 32'(want.bad_sequence));
                if (got.char_count !== want.char_count)
                    report("char_count", 32'(got.char_count), 32'(want.char_count));
                if (got.bytes_to_accept !== want.bytes_to_accept)
                    report("bytes_to_accept", 32'(got.bytes_to_accept),
                           32'(want.bytes_to_accept));
            end
            results_seen++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    utf8_in_if  in_ch ();
    utf8_out_if out_ch ();

    utf8_dfa_decoder #(
        .MAX_STRING_BYTES (MAX_BYTES)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf8_decode_scoreboard sb = new();

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned hold_cycles;
    logic [7:0]  str_q[$];

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Encode one code point into the string under construction.
    function automatic void add_code(int unsigned cp);
        if (cp < 32'h80) begin
            str_q.push_back(cp[7:0]);
        end else if (cp < 32'h800) begin
            str_q.push_back(8'hC0 | cp[10:6]);
            str_q.push_back(8'h80 | cp[5:0]);
        end else if (cp < 32'h10000) begin
            str_q.push_back(8'hE0 | cp[15:12]);
            str_q.push_back(8'h80 | cp[11:6]);
            str_q.push_back(8'h80 | cp[5:0]);
        end else begin
            str_q.push_back(8'hF0 | cp[20:18]);
            str_q.push_back(8'h80 | cp[17:12]);
            str_q.push_back(8'h80 | cp[11:6]);
            str_q.push_back(8'h80 | cp[5:0]);
        end
    endfunction

    function automatic int unsigned random_code();
        int unsigned cp;
        case ($urandom_range(3, 0))
            0:       cp = $urandom_range(32'h7F, 0);
            1:       cp = $urandom_range(32'h7FF, 32'h80);
            2: begin
                cp = $urandom_range(32'hFFFF, 32'h800);
                // move surrogates out of the way
                if (cp >= 32'hD800 && cp <= 32'hDFFF)
                    cp = cp ^ 32'h2000;
            end
            default: cp = $urandom_range(32'h10FFFF, 32'h10000);
        endcase
        return cp;
    endfunction

    // Mostly well-formed characters, with stray bytes and cut-off sequences mixed in.
    function automatic void build_random_string(int unsigned len);
        int unsigned k;
        str_q.delete();
        while (str_q.size() < len) begin
            k = $urandom_range(99, 0);
            if (k < 78) begin
                add_code(random_code());
            end else if (k < 88) begin
                str_q.push_back(8'($urandom));
            end else begin
                add_code(random_code() | 32'h80);
                void'(str_q.pop_back());
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item item;
        item.data_byte = b;
        item.last_byte = last;
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_byte(item);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial begin : sink_side
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    initial begin : watch
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (rst_n && out_ch.valid && out_ch.ready) begin
                quiet = 0;
                sb.check_result(out_ch.data);
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned sent;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes of each sequence length, including the restricted second bytes
        str_q = {8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF,
                 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF};
        send_string();
        str_q = {8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // sticky reject; the accumulator keeps shifting past its width
        str_q = {8'h41, 8'hC0, 8'hFF, 8'h80, 8'hBF, 8'h41};
        send_string();
        // string closed in the middle of a sequence, then a lone invalid byte
        str_q = {8'hE0, 8'h80};
        send_string();
        str_q = {8'hF5};
        send_string();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 60; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            sent = 0;
            while (sent < 150) begin
                build_random_string($urandom_range(24, 1));
                sent += str_q.size();
                send_string();
            end
            drain();
        end

        // back-pressure: stall the output long enough to fill the pipe
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 400;
        sent = 0;
        while (sent < 80) begin
            build_random_string($urandom_range(24, 1));
            sent += str_q.size();
            send_string();
        end
        drain();

        // one long string, mostly ASCII with multibyte characters between
        str_q.delete();
        while (str_q.size() < 120) begin
            if ($urandom_range(99, 0) < 90)
                str_q.push_back(8'($urandom_range(8'h7F, 0)));
            else
                add_code(random_code());
        end
        send_string();
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: utf8_dfa_decoder.f
design/utf8_pkg.sv
design/utf8_if.sv
design/utf8_front.sv
design/utf8_core.sv
design/utf8_dfa_decoder.sv
tb/sv/tb.sv
